### hw/rtl/ttok_pkg.sv
// ttok_pkg: shared types, constants and byte-class helpers for the text tokenizer.
// Used by ttok_core, ttok_rsp_queue and text_category_tokenizer. No dependencies.
`default_nettype none

package ttok_pkg;

   // Offset counter width; offsets saturate at all ones.
   localparam int OFFSET_BITS = 16;
   localparam int OUT_OFFSET_BITS = 16;

   // Token kinds (space is internal only)
   localparam logic [1:0] KIND_LETTER = 2'd0;
   localparam logic [1:0] KIND_DIGIT  = 2'd1;
   localparam logic [1:0] KIND_OTHER  = 2'd2;
   localparam logic [1:0] KIND_SPACE  = 2'd3;

   // Result queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]                 token_byte;
      logic                       token_first;
      logic                       token_last;
      logic [1:0]                 token_kind;
      logic [OUT_OFFSET_BITS-1:0] start_offset;
      logic [OUT_OFFSET_BITS-1:0] end_offset;
      logic                       text_done;
   } rsp_type;

   // Results produced by one request, packed from slot0 upward.
   typedef struct packed {
      logic [1:0] push_count;
      rsp_type    slot0;
      rsp_type    slot1;
   } push_type;

   function automatic logic [1:0] class_of(input logic [7:0] b);
      logic [1:0] k;
      if (b > 8'd127) begin
         k = KIND_OTHER;
      end else if (b >= 8'h30 && b <= 8'h39) begin
         k = KIND_DIGIT;
      end else if (b <= 8'd32 || b == 8'd127) begin
         k = KIND_SPACE;
      end else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
         k = KIND_LETTER;
      end else begin
         k = KIND_OTHER;
      end
      return k;
   endfunction

   // UTF-8 sequence length minus one, from the lead byte
   function automatic logic [1:0] seq_tail(input logic [7:0] b);
      logic [1:0] n;
      if (b >= 8'hF0) begin
         n = 2'd3;
      end else if (b >= 8'hE0) begin
         n = 2'd2;
      end else if (b >= 8'hC0) begin
         n = 2'd1;
      end else begin
         n = 2'd0;
      end
      return n;
   endfunction

   // Low output bits of an offset, zero-extended when the counter is narrower
   function automatic logic [OUT_OFFSET_BITS-1:0] to_out_offset(
      input logic [OFFSET_BITS-1:0] v);
      logic [OFFSET_BITS+OUT_OFFSET_BITS-1:0] wide;
      wide = {{OUT_OFFSET_BITS{1'b0}}, v};
      return wide[OUT_OFFSET_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/ttok_core.sv
// ttok_core: tokenizer state registers and the per-byte step logic.
// Depends on ttok_pkg; produces up to two results per request for the queue.
`default_nettype none

module ttok_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire ttok_pkg::req_type item,
   output ttok_pkg::push_type    push
);
   import ttok_pkg::*;

   logic [7:0]             held_byte_ff, held_byte_in;
   logic                   held_valid_ff, held_valid_in;
   logic                   held_first_ff, held_first_in;
   logic [1:0]             run_kind_ff, run_kind_in;
   logic [1:0]             seq_left_ff, seq_left_in;
   logic [OFFSET_BITS-1:0] run_start_ff, run_start_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;

   logic [1:0]             cls;
   logic                   cont;
   logic                   keep;
   logic                   cur_first;
   logic [1:0]             kind_n;
   logic [1:0]             seq_n;
   logic [OFFSET_BITS-1:0] start_n;
   logic [OFFSET_BITS-1:0] pos_next;
   logic [7:0]             byte_out;
   logic                   res1_valid;
   rsp_type                res0;
   rsp_type                res1;

   always_comb begin
      cls      = class_of(item.data_byte);
      pos_next = (pos_ff == {OFFSET_BITS{1'b1}}) ? pos_ff : pos_ff + OFFSET_BITS'(1);
      cont     = (seq_left_ff != 2'd0) ||
                 ((run_kind_ff == KIND_LETTER || run_kind_ff == KIND_DIGIT) &&
                  cls == run_kind_ff);

      // Held byte closes out with its last mark now known
      res0.token_byte   = held_byte_ff;
      res0.token_first  = held_first_ff;
      res0.token_last   = !cont;
      res0.token_kind   = run_kind_ff;
      res0.start_offset = to_out_offset(run_start_ff);
      res0.end_offset   = cont ? '0 : to_out_offset(pos_ff);
      res0.text_done    = item.last_byte && !cont && cls == KIND_SPACE;

      kind_n    = run_kind_ff;
      start_n   = run_start_ff;
      seq_n     = seq_left_ff;
      cur_first = 1'b0;
      keep      = 1'b1;
      if (cont) begin
         seq_n = (seq_left_ff != 2'd0) ? seq_left_ff - 2'd1 : 2'd0;
      end else if (cls == KIND_SPACE) begin
         kind_n = KIND_SPACE;
         keep   = 1'b0;
      end else begin
         kind_n    = cls;
         start_n   = pos_ff;
         cur_first = 1'b1;
         seq_n     = (cls == KIND_OTHER) ? seq_tail(item.data_byte) : 2'd0;
      end

      byte_out = item.data_byte;
      if (keep && kind_n == KIND_LETTER && item.data_byte >= 8'h41 &&
          item.data_byte <= 8'h5A) begin
         byte_out = item.data_byte | 8'h20;
      end

      // End of text flushes the current byte as a closing result
      res1_valid        = item.last_byte && keep;
      res1.token_byte   = byte_out;
      res1.token_first  = cur_first;
      res1.token_last   = 1'b1;
      res1.token_kind   = kind_n;
      res1.start_offset = to_out_offset(start_n);
      res1.end_offset   = to_out_offset(pos_next);
      res1.text_done    = 1'b1;

      push.push_count = 2'd0;
      push.slot0      = res1;
      push.slot1      = res1;
      if (fire) begin
         push.push_count = {1'b0, held_valid_ff} + {1'b0, res1_valid};
         if (held_valid_ff) begin
            push.slot0 = res0;
         end
      end

      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      held_first_in = held_first_ff;
      run_kind_in   = run_kind_ff;
      seq_left_in   = seq_left_ff;
      run_start_in  = run_start_ff;
      pos_in        = pos_ff;
      if (fire) begin
         if (item.last_byte) begin
            held_byte_in  = 8'd0;
            held_valid_in = 1'b0;
            held_first_in = 1'b0;
            run_kind_in   = KIND_SPACE;
            seq_left_in   = 2'd0;
            run_start_in  = '0;
            pos_in        = '0;
         end else begin
            held_byte_in  = keep ? byte_out : 8'd0;
            held_valid_in = keep;
            held_first_in = keep && cur_first;
            run_kind_in   = kind_n;
            seq_left_in   = seq_n;
            run_start_in  = start_n;
            pos_in        = pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff  <= 8'd0;
         held_valid_ff <= 1'b0;
         held_first_ff <= 1'b0;
         run_kind_ff   <= KIND_SPACE;
         seq_left_ff   <= 2'd0;
         run_start_ff  <= '0;
         pos_ff        <= '0;
      end else begin
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         held_first_ff <= held_first_in;
         run_kind_ff   <= run_kind_in;
         seq_left_ff   <= seq_left_in;
         run_start_ff  <= run_start_in;
         pos_ff        <= pos_in;
      end
   end

   a_text_end_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.last_byte |=> !held_valid_ff && pos_ff == '0 && seq_left_ff == 2'd0)
      else $error("state not cleared after end of text");

   a_first_needs_held: assert property (@(posedge clock) disable iff (reset)
      held_first_ff |-> held_valid_ff)
      else $error("first mark without a held byte");

   a_seq_in_other: assert property (@(posedge clock) disable iff (reset)
      seq_left_ff != 2'd0 |-> run_kind_ff == KIND_OTHER && held_valid_ff)
      else $error("pending UTF-8 tail outside an other token");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      fire && !item.last_byte && pos_ff != {OFFSET_BITS{1'b1}}
      |=> pos_ff == $past(pos_ff) + OFFSET_BITS'(1))
      else $error("byte position did not advance");

endmodule

`default_nettype wire

### hw/rtl/ttok_rsp_queue.sv
// ttok_rsp_queue: small result queue taking up to two results per cycle.
// Depends on ttok_pkg; drives the rsp_ channel of the top level.
`default_nettype none

module ttok_rsp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ttok_pkg::push_type push,
   output logic                  room,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ttok_pkg::rsp_type     rsp_data
);
   import ttok_pkg::*;

   rsp_type               mem [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  head_ff, head_in;
   logic [QPTR_BITS-1:0]  tail_ff, tail_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem[head_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // Two free slots guaranteed before a request is taken
   assign room      = (count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));

   always_comb begin
      head_in  = pop ? head_ff + QPTR_BITS'(1) : head_ff;
      tail_in  = tail_ff + QPTR_BITS'(push.push_count);
      count_in = count_ff + QCNT_BITS'(push.push_count) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push_count != 2'd0) begin
         mem[tail_ff] <= push.slot0;
      end
      if (push.push_count == 2'd2) begin
         mem[tail_ff + QPTR_BITS'(1)] <= push.slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("result queue overflow");

endmodule

`default_nettype wire

### hw/rtl/text_category_tokenizer.sv
// text_category_tokenizer: top level, input register, step core and result queue.
// Depends on ttok_pkg, ttok_core and ttok_rsp_queue.
`default_nettype none

// Streaming byte tokenizer. Each request carries one text byte and a flag on
// the final byte. Bytes are classed as space/control, ASCII letter, digit or
// other; letter runs and digit runs each form a token, and every other-class
// lead byte opens a token of its UTF-8 length (1 to 4 bytes) that the end of
// text cuts short. Spaces are dropped and letters come out lowercased. Each
// token byte leaves one request late with first/last marks, its kind and the
// token's start and end offsets (end only on the last byte). The final byte of
// a text flushes everything and the next byte starts over at offset 0.
// Rate: one request per cycle unless req_stall is raised. A request yields
// zero, one or two responses; two only on the final byte of a text while a
// token is open. The response port drains one response per cycle while
// rsp_stall is low, so a two-response request backs up there; a four-entry
// response queue absorbs it and the input register stalls only when fewer
// than two queue slots are free. A response enters the queue register when
// the request that causes it is consumed from the input register.
module text_category_tokenizer (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire ttok_pkg::req_type req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output ttok_pkg::rsp_type  rsp_data
);
   import ttok_pkg::*;

   logic     in_valid_ff, in_valid_in;
   req_type  in_ff;
   logic     room;
   logic     fire;
   push_type push;

   // Request register: holds one byte until the core consumes it
   assign fire        = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign in_valid_in = (req_valid && !req_stall) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
   end

   ttok_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_ff),
      .push  (push)
   );

   ttok_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_push_on_fire: assert property (@(posedge clock) disable iff (reset)
      push.push_count != 2'd0 |-> fire)
      else $error("responses pushed without a consumed request");

   a_two_only_at_end: assert property (@(posedge clock) disable iff (reset)
      push.push_count == 2'd2 |-> in_ff.last_byte && push.slot1.text_done)
      else $error("two responses from a byte that does not end the text");

   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_ff))
      else $error("request register lost an unconsumed byte");

endmodule

`default_nettype wire
